// ===== hw/rtl/retransmit_window_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// Retransmit window tracker assertion macros
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RETRANSMIT_WINDOW_TRACKER_DEFINES_SVH
`define RETRANSMIT_WINDOW_TRACKER_DEFINES_SVH

// same-cycle implication
`define RWT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rwt_pkg.sv =====
// ----------------------------------------------------------------------------
// rwt_pkg
// Shared types and constants of the retransmit window tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package rwt_pkg;

  localparam int unsigned SEQ_W    = 15;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned ACK_W    = 15;
  localparam int unsigned CREDIT_W = 16;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned NEED_W   = 12;
  localparam int unsigned TYPE_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned WINDOW_ENTRIES_DEF = 8;
  localparam int unsigned HEADER_BYTES       = 8;
  localparam int unsigned MAX_PAYLOAD        = 1024;
  localparam int unsigned RESULTS_MAX        = 8;
  localparam int unsigned CMD_Q_DEPTH        = 2;
  localparam int unsigned OUT_Q_DEPTH        = 4;

  localparam logic [CREDIT_W-1:0] CREDIT_RESET  = 16'd5120;
  localparam logic [15:0]         TIMEOUT_RESET = 16'd500;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SEQ   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BYTES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

  typedef enum logic [TYPE_W-1:0] {
    OP_RESTART = 2'd0,
    OP_SEND    = 2'd1,
    OP_ACK     = 2'd2,
    OP_TICK    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_FREE,
    ST_TICK
  } st_t;

  typedef struct packed {
    logic [SEQ_W-1:0]    initial_seq;
    logic [CREDIT_W-1:0] window_bytes;
    logic [15:0]         timeout_ticks;
  } cfg_t;

  typedef struct packed {
    op_t               op;
    logic [LEN_W-1:0]  len;
    logic [ACK_W-1:0]  ack;
    logic [NEED_W-1:0] need;
    logic              len_ok;
  } cmd_t;

  typedef struct packed {
    logic                accepted;
    logic [SEQ_W-1:0]    seq;
    logic [LEN_W-1:0]    len;
    logic                retransmit;
    logic [CNT_W-1:0]    freed;
    logic [CREDIT_W-1:0] credit;
    logic [CNT_W-1:0]    used;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rwt_fifo.sv =====
// ----------------------------------------------------------------------------
// rwt_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module rwt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             wr;
  logic             rd;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign wr      = push && !full;
  assign rd      = pop && !empty;
  assign rd_data = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (rd) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (wr && !rd) begin
        count_r <= count_r + CW'(1);
      end else if (rd && !wr) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rwt_front.sv =====
// ----------------------------------------------------------------------------
// rwt_front
// Decodes an input beat into a command: opcode, byte need and length check.
// ----------------------------------------------------------------------------
`default_nettype none

module rwt_front (
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [rwt_pkg::TYPE_W-1:0] in_req_type,
  input  logic [rwt_pkg::LEN_W-1:0]  in_data_length,
  input  logic [rwt_pkg::ACK_W-1:0]  in_ack_number,
  input  logic                       cmd_full,
  output logic                       cmd_push,
  output rwt_pkg::cmd_t              cmd
);

  assign in_full  = cmd_full;
  assign cmd_push = in_push && !cmd_full;

  always_comb begin
    cmd.op     = rwt_pkg::op_t'(in_req_type);
    cmd.len    = in_data_length;
    cmd.ack    = in_ack_number;
    cmd.need   = rwt_pkg::NEED_W'(in_data_length)
               + rwt_pkg::NEED_W'(rwt_pkg::HEADER_BYTES);
    cmd.len_ok = (in_data_length != '0)
              && (in_data_length <= rwt_pkg::LEN_W'(rwt_pkg::MAX_PAYLOAD));
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rwt_back.sv =====
// ----------------------------------------------------------------------------
// rwt_back
// Window engine: entry memory, ack flags, credit and sequence state, and the
// scan sequencer that marks, frees and times out entries.
// ----------------------------------------------------------------------------
`default_nettype none

module rwt_back #(
  parameter int unsigned WINDOW_ENTRIES = rwt_pkg::WINDOW_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rwt_pkg::cfg_t cfg,
  input  logic          cmd_valid,
  input  rwt_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          out_full,
  output logic          out_push,
  output rwt_pkg::res_t out_res
);

  localparam int unsigned IW  = (WINDOW_ENTRIES > 1) ? $clog2(WINDOW_ENTRIES) : 1;
  localparam int unsigned UW  = $clog2(WINDOW_ENTRIES + 1);
  localparam int unsigned SW  = UW + 1;
  localparam int unsigned CSW = rwt_pkg::CREDIT_W + 1;
  localparam int unsigned CNW = rwt_pkg::CNT_W;

  typedef struct packed {
    logic [rwt_pkg::SEQ_W-1:0]   seq;
    logic [rwt_pkg::LEN_W-1:0]   len;
    logic [rwt_pkg::STAMP_W-1:0] stamp;
  } entry_t;

  entry_t entry_mem [WINDOW_ENTRIES];
  entry_t rd_data_r;

  rwt_pkg::st_t st_r, st_nxt;
  logic [IW-1:0]                 head_r, head_nxt;
  logic [UW-1:0]                 used_r, used_nxt;
  logic [rwt_pkg::SEQ_W-1:0]     next_seq_r, next_seq_nxt;
  logic [rwt_pkg::CREDIT_W-1:0]  credit_r, credit_nxt;
  logic [rwt_pkg::STAMP_W-1:0]   now_r, now_nxt;
  logic [WINDOW_ENTRIES-1:0]     acked_r, acked_nxt;
  logic [UW-1:0]                 idx_r, idx_nxt;
  logic                          pv_r, pv_nxt;
  logic [IW-1:0]                 pslot_r, pslot_nxt;
  logic [CNW-1:0]                hits_r, hits_nxt;
  logic                          hold_v_r, hold_v_nxt;
  logic [rwt_pkg::SEQ_W-1:0]     hold_seq_r, hold_seq_nxt;
  logic [rwt_pkg::LEN_W-1:0]     hold_len_r, hold_len_nxt;

  logic          mem_we;
  logic [IW-1:0] mem_wa;
  entry_t        mem_wd;
  logic          rd_en;
  logic [IW-1:0] scan_slot;
  logic [IW-1:0] tail_slot;

  logic [rwt_pkg::SEQ_W-1:0]   rd_end;
  logic [rwt_pkg::STAMP_W-1:0] age;
  logic [CSW-1:0]              credit_sum;
  logic                        timed_out;
  logic                        send_ok;
  logic                        mark_issue;
  logic                        free_issue;
  logic                        tick_issue;
  logic                        tick_hit;
  logic                        tick_stall;
  logic                        issue;
  logic                        scan_idle;
  logic                        ack_end;
  logic                        tick_end;

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                            input logic [UW-1:0] k);
    logic [SW-1:0] acc;
    acc = SW'(base) + SW'(k);
    if (acc >= SW'(WINDOW_ENTRIES)) begin
      acc = acc - SW'(WINDOW_ENTRIES);
    end
    return acc[IW-1:0];
  endfunction

  assign scan_slot = slot_of(head_r, idx_r);
  assign tail_slot = slot_of(head_r, used_r);

  assign rd_end     = rd_data_r.seq + rwt_pkg::SEQ_W'(rd_data_r.len);
  assign age        = now_r - rd_data_r.stamp;
  assign credit_sum = CSW'(credit_r) + CSW'(rd_data_r.len) + CSW'(rwt_pkg::HEADER_BYTES);
  assign timed_out  = !acked_r[pslot_r] && (age >= rwt_pkg::STAMP_W'(cfg.timeout_ticks));
  assign send_ok    = cmd.len_ok
                   && (credit_r >= rwt_pkg::CREDIT_W'(cmd.need))
                   && (used_r < UW'(WINDOW_ENTRIES));

  assign mark_issue = (st_r == rwt_pkg::ST_MARK) && (idx_r < used_r);
  assign free_issue = (st_r == rwt_pkg::ST_FREE) && (idx_r < used_r) && acked_r[scan_slot];
  assign tick_hit   = (st_r == rwt_pkg::ST_TICK) && pv_r && timed_out
                   && (hits_r < CNW'(rwt_pkg::RESULTS_MAX));
  assign tick_stall = tick_hit && hold_v_r && out_full;
  assign tick_issue = (st_r == rwt_pkg::ST_TICK) && (idx_r < used_r)
                   && (hits_r < CNW'(rwt_pkg::RESULTS_MAX)) && !tick_stall;
  assign issue      = mark_issue || free_issue || tick_issue;
  assign scan_idle  = !issue && !pv_r;
  assign ack_end    = (st_r == rwt_pkg::ST_FREE) && scan_idle && !out_full;
  assign tick_end   = (st_r == rwt_pkg::ST_TICK) && scan_idle && !out_full;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rwt_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            rwt_pkg::OP_ACK:  st_nxt = rwt_pkg::ST_MARK;
            rwt_pkg::OP_TICK: st_nxt = rwt_pkg::ST_TICK;
            default:          st_nxt = rwt_pkg::ST_IDLE;
          endcase
        end
      end
      rwt_pkg::ST_MARK: begin
        if (scan_idle) begin
          st_nxt = rwt_pkg::ST_FREE;
        end
      end
      rwt_pkg::ST_FREE: begin
        if (ack_end) begin
          st_nxt = rwt_pkg::ST_IDLE;
        end
      end
      rwt_pkg::ST_TICK: begin
        if (tick_end) begin
          st_nxt = rwt_pkg::ST_IDLE;
        end
      end
      default: st_nxt = rwt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    head_nxt     = head_r;
    used_nxt     = used_r;
    next_seq_nxt = next_seq_r;
    credit_nxt   = credit_r;
    now_nxt      = now_r;
    acked_nxt    = acked_r;
    hits_nxt     = hits_r;
    hold_v_nxt   = hold_v_r;
    hold_seq_nxt = hold_seq_r;
    hold_len_nxt = hold_len_r;
    idx_nxt      = issue ? idx_r + UW'(1) : idx_r;
    pv_nxt       = issue;
    pslot_nxt    = scan_slot;
    rd_en        = issue;
    mem_we       = 1'b0;
    mem_wa       = pslot_r;
    mem_wd       = rd_data_r;
    cmd_pop      = 1'b0;
    out_push     = 1'b0;
    out_res      = '0;

    case (st_r)
      rwt_pkg::ST_IDLE: begin
        idx_nxt    = '0;
        hits_nxt   = '0;
        hold_v_nxt = 1'b0;
        if (cmd_valid) begin
          case (cmd.op)
            rwt_pkg::OP_RESTART: begin
              if (!out_full) begin
                next_seq_nxt   = cfg.initial_seq;
                credit_nxt     = cfg.window_bytes;
                acked_nxt      = '0;
                head_nxt       = '0;
                used_nxt       = '0;
                cmd_pop        = 1'b1;
                out_push       = 1'b1;
                out_res.credit = cfg.window_bytes;
                out_res.last   = 1'b1;
              end
            end
            rwt_pkg::OP_SEND: begin
              if (!out_full) begin
                cmd_pop      = 1'b1;
                out_push     = 1'b1;
                out_res.last = 1'b1;
                if (send_ok) begin
                  mem_we              = 1'b1;
                  mem_wa              = tail_slot;
                  mem_wd.seq          = next_seq_r;
                  mem_wd.len          = cmd.len;
                  mem_wd.stamp        = now_r;
                  acked_nxt[tail_slot] = 1'b0;
                  used_nxt            = used_r + UW'(1);
                  next_seq_nxt        = next_seq_r + rwt_pkg::SEQ_W'(cmd.len);
                  credit_nxt          = credit_r - rwt_pkg::CREDIT_W'(cmd.need);
                  out_res.accepted    = 1'b1;
                  out_res.seq         = next_seq_r;
                  out_res.len         = cmd.len;
                end
                out_res.credit = credit_nxt;
                out_res.used   = CNW'(used_nxt);
              end
            end
            rwt_pkg::OP_TICK: begin
              now_nxt = now_r + rwt_pkg::STAMP_W'(1);
            end
            default: begin
            end
          endcase
        end
      end

      rwt_pkg::ST_MARK: begin
        if (pv_r && (rd_end == cmd.ack)) begin
          acked_nxt[pslot_r] = 1'b1;
        end
        if (scan_idle) begin
          idx_nxt = '0;
        end
      end

      rwt_pkg::ST_FREE: begin
        if (pv_r) begin
          credit_nxt         = credit_sum[CSW-1] ? '1 : credit_sum[rwt_pkg::CREDIT_W-1:0];
          acked_nxt[pslot_r] = 1'b0;
        end
        if (ack_end) begin
          head_nxt       = scan_slot;
          used_nxt       = used_r - idx_r;
          cmd_pop        = 1'b1;
          out_push       = 1'b1;
          out_res.freed  = CNW'(idx_r);
          out_res.credit = credit_r;
          out_res.used   = CNW'(used_nxt);
          out_res.last   = 1'b1;
        end
      end

      rwt_pkg::ST_TICK: begin
        if (tick_stall) begin
          pv_nxt    = 1'b1;
          pslot_nxt = pslot_r;
        end else if (tick_hit) begin
          if (hold_v_r) begin
            out_push           = 1'b1;
            out_res.seq        = hold_seq_r;
            out_res.len        = hold_len_r;
            out_res.retransmit = 1'b1;
            out_res.credit     = credit_r;
            out_res.used       = CNW'(used_r);
          end
          hold_v_nxt   = 1'b1;
          hold_seq_nxt = rd_data_r.seq;
          hold_len_nxt = rd_data_r.len;
          hits_nxt     = hits_r + CNW'(1);
          mem_we       = 1'b1;
          mem_wa       = pslot_r;
          mem_wd.stamp = now_r;
        end
        if (tick_end) begin
          cmd_pop        = 1'b1;
          out_push       = 1'b1;
          out_res.credit = credit_r;
          out_res.used   = CNW'(used_r);
          out_res.last   = 1'b1;
          if (hold_v_r) begin
            out_res.seq        = hold_seq_r;
            out_res.len        = hold_len_r;
            out_res.retransmit = 1'b1;
          end
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= entry_mem[scan_slot];
    end
  end

  always_ff @(posedge clk) begin
    hold_seq_r <= hold_seq_nxt;
    hold_len_r <= hold_len_nxt;
    pslot_r    <= pslot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= rwt_pkg::ST_IDLE;
      head_r     <= '0;
      used_r     <= '0;
      next_seq_r <= '0;
      credit_r   <= rwt_pkg::CREDIT_RESET;
      now_r      <= '0;
      acked_r    <= '0;
      idx_r      <= '0;
      pv_r       <= 1'b0;
      hits_r     <= '0;
      hold_v_r   <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      head_r     <= head_nxt;
      used_r     <= used_nxt;
      next_seq_r <= next_seq_nxt;
      credit_r   <= credit_nxt;
      now_r      <= now_nxt;
      acked_r    <= acked_nxt;
      idx_r      <= idx_nxt;
      pv_r       <= pv_nxt;
      hits_r     <= hits_nxt;
      hold_v_r   <= hold_v_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/retransmit_window_tracker.sv =====
// ----------------------------------------------------------------------------
// retransmit_window_tracker
// Sender window of unacknowledged segments. Items enter through a decoder and
// a two-entry command queue; a window engine executes them against an entry
// ring held in a memory with a write port and a registered read port, and
// its results wait in a four-entry result queue. The input side takes one item
// per cycle while the command queue has room. In the engine a restart or send
// item completes once the result queue has room; an ack item runs a mark pass
// and then a free pass, each reading one entry per cycle through the memory
// read port, draining the last read and then closing the pass; a tick item
// reads one entry per cycle while it is not held by a full result queue.
// Configuration writes are always ready; the engine reads the registered
// configuration while it executes an item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "retransmit_window_tracker_defines.svh"

module retransmit_window_tracker #(
  parameter int unsigned WINDOW_ENTRIES = rwt_pkg::WINDOW_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_push,
  output logic                           in_full,
  input  logic [rwt_pkg::TYPE_W-1:0]     in_req_type,
  input  logic [rwt_pkg::LEN_W-1:0]      in_data_length,
  input  logic [rwt_pkg::ACK_W-1:0]      in_ack_number,

  output logic                           out_empty,
  input  logic                           out_pop,
  output logic                           out_accepted,
  output logic [rwt_pkg::SEQ_W-1:0]      out_segment_seq,
  output logic [rwt_pkg::LEN_W-1:0]      out_segment_length,
  output logic                           out_is_retransmit,
  output logic [rwt_pkg::CNT_W-1:0]      out_freed_count,
  output logic [rwt_pkg::CREDIT_W-1:0]   out_credit_left,
  output logic [rwt_pkg::CNT_W-1:0]      out_entries_in_use,
  output logic                           out_last,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rwt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rwt_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CMD_W = $bits(rwt_pkg::cmd_t);
  localparam int unsigned RES_W = $bits(rwt_pkg::res_t);

  rwt_pkg::cfg_t cfg_r;
  rwt_pkg::cmd_t cmd_w;
  rwt_pkg::cmd_t cmd_head;
  rwt_pkg::res_t out_res_w;
  rwt_pkg::res_t out_head;

  logic             cmd_push;
  logic             cmd_full;
  logic             cmd_empty;
  logic             cmd_pop;
  logic [CMD_W-1:0] cmd_head_vec;
  logic             out_push;
  logic             out_q_full;
  logic [RES_W-1:0] out_head_vec;
  logic             last_push;
  logic             part_push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.initial_seq   <= '0;
      cfg_r.window_bytes  <= rwt_pkg::CREDIT_RESET;
      cfg_r.timeout_ticks <= rwt_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rwt_pkg::CFG_INITIAL_SEQ:   cfg_r.initial_seq   <= cfg_data[rwt_pkg::SEQ_W-1:0];
        rwt_pkg::CFG_WINDOW_BYTES:  cfg_r.window_bytes  <= cfg_data;
        rwt_pkg::CFG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rwt_front u_front (
    .in_push        (in_push),
    .in_full        (in_full),
    .in_req_type    (in_req_type),
    .in_data_length (in_data_length),
    .in_ack_number  (in_ack_number),
    .cmd_full       (cmd_full),
    .cmd_push       (cmd_push),
    .cmd            (cmd_w)
  );

  rwt_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (rwt_pkg::CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_w),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_head_vec),
    .empty   (cmd_empty)
  );

  assign cmd_head = cmd_head_vec;

  rwt_back #(
    .WINDOW_ENTRIES (WINDOW_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_full  (out_q_full),
    .out_push  (out_push),
    .out_res   (out_res_w)
  );

  rwt_fifo #(
    .WIDTH (RES_W),
    .DEPTH (rwt_pkg::OUT_Q_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (out_push),
    .wr_data (out_res_w),
    .full    (out_q_full),
    .pop     (out_pop),
    .rd_data (out_head_vec),
    .empty   (out_empty)
  );

  assign out_head           = out_head_vec;
  assign out_accepted       = out_head.accepted;
  assign out_segment_seq    = out_head.seq;
  assign out_segment_length = out_head.len;
  assign out_is_retransmit  = out_head.retransmit;
  assign out_freed_count    = out_head.freed;
  assign out_credit_left    = out_head.credit;
  assign out_entries_in_use = out_head.used;
  assign out_last           = out_head.last;

  assign last_push = out_push && out_res_w.last;
  assign part_push = out_push && !out_res_w.last;

  `RWT_ASSERT_SAME(a_retire_with_last, cmd_pop, last_push, "retire without final beat")
  `RWT_ASSERT_SAME(a_last_retires, last_push, cmd_pop, "final beat without retire")
  `RWT_ASSERT_SAME(a_part_tick, part_push, cmd_head.op == rwt_pkg::OP_TICK, "stray partial beat")
  `RWT_ASSERT_NEXT(a_push_lands, out_push, !out_empty, "pushed result missing from queue")

endmodule

`default_nettype wire
